>>> design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types and codes for the string unescaper and UTF-8 checker.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // Result kinds carried on the response channel.
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_QUOTE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Parser modes.
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_STR     = 3'd1;
   localparam logic [2:0] MODE_ESC     = 3'd2;
   localparam logic [2:0] MODE_HEX1    = 3'd3;
   localparam logic [2:0] MODE_NEED_BS = 3'd4;
   localparam logic [2:0] MODE_NEED_U  = 3'd5;
   localparam logic [2:0] MODE_HEX2    = 3'd6;
   localparam logic [2:0] MODE_UTF8    = 3'd7;

   // Parser state carried from one byte to the next.
   typedef struct packed {
      logic [2:0]       mode;
      logic [2:0]       hex_left;
      logic [20:0]      acc;
      logic [9:0]       hi;
      logic [2:0][7:0]  held;
      logic [1:0]       cont;
      logic [1:0]       cls;
   } jsu_state_type;

   // All results caused by one input word: up to four data bytes, or a
   // single quote or error result.
   typedef struct packed {
      logic [2:0]       count;
      logic [1:0]       kind;
      logic [3:0][7:0]  bytes;
   } jsu_bundle_type;

   localparam jsu_state_type STATE_CLEAR = '{
      mode:     MODE_IDLE,
      hex_left: 3'd0,
      acc:      21'd0,
      hi:       10'd0,
      held:     24'd0,
      cont:     2'd0,
      cls:      2'd0
   };

endpackage

>>> design/jsu_req_if.sv
// ----------------------------------------------------------------------------
// JSON unescaper request channel
// Carries one raw byte of the string token, or an end-of-buffer mark.
// ----------------------------------------------------------------------------
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_mark;

   modport source (output valid, output data_byte, output end_mark, input ready);
   modport sink   (input valid, input data_byte, input end_mark, output ready);
endinterface

>>> design/jsu_rsp_if.sv
// ----------------------------------------------------------------------------
// JSON unescaper response channel
// Carries one decoded byte, a closing quote mark or an error mark.
// ----------------------------------------------------------------------------
interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] kind;
   logic       last_of_run;

   modport source (output valid, output out_byte, output kind, output last_of_run,
                   input ready);
   modport sink   (input valid, input out_byte, input kind, input last_of_run,
                   output ready);
endinterface

>>> design/json_string_unescape_utf8_check.sv
// A request word is held in the input register; its results leave from the result stage.
// Throughput: one request word per cycle while each word causes at most one result and the
// response side is ready; a word with N results holds it until all are taken (N up to 4).
// Reset: synchronous, active high; clears both stages and returns the parser to idle.
// ----------------------------------------------------------------------------
// JSON string unescaper with UTF-8 validation
// Decodes the bytes of one JSON string token into UTF-8 and flags errors.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_check
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   jsu_req_if.sink     req_ch,
   jsu_rsp_if.source   rsp_ch
);

   // The design is a two-stage pipeline. The first stage is an input register
   // that holds one request word. The decoder reads that word together with
   // the parser state and combinationally produces the whole set of results for
   // it. The parser state advances when the word leaves the first stage.
   //
   // The second stage holds that result set and hands it out one word per
   // cycle while the response side is ready. A word that causes no result (a
   // backslash, a hex digit, the lead byte of a multibyte sequence) leaves the
   // first stage at once, without waiting for the second stage.
   //
   // The first stage refills in the cycle that the second stage hands out
   // its last word, so a stream of single-result words moves at one word per
   // cycle while the response side is ready.

   // Input stage.
   logic           a_valid_ff, a_valid_in;
   logic [7:0]     a_byte_ff, a_byte_in;
   logic           a_end_ff, a_end_in;

   // Parser state.
   jsu_state_type  state_ff, state_in;

   // Result stage: the result set and the position of the word on offer.
   logic           b_valid_ff, b_valid_in;
   jsu_bundle_type bundle_ff, bundle_in;
   logic [1:0]     idx_ff, idx_in;

   jsu_state_type  dec_state;
   jsu_bundle_type dec_res;

   logic           b_last;
   logic           b_done;
   logic           b_free;
   logic           a_adv;
   logic           req_take;

   jsu_decode u_decode (
      .cur       (state_ff),
      .data_byte (a_byte_ff),
      .end_mark  (a_end_ff),
      .nxt       (dec_state),
      .res       (dec_res)
   );

   // The word on offer is the last of its set when its position is count - 1.
   assign b_last   = ({1'b0, idx_ff} == (bundle_ff.count - 3'd1));
   assign b_done   = b_valid_ff && rsp_ch.ready && b_last;
   assign b_free   = !b_valid_ff || b_done;

   // A word with no results never waits on the result stage.
   assign a_adv    = a_valid_ff && ((dec_res.count == 3'd0) || b_free);
   assign req_take = !a_valid_ff || a_adv;

   assign req_ch.ready       = req_take;
   assign rsp_ch.valid       = b_valid_ff;
   assign rsp_ch.out_byte    = bundle_ff.bytes[idx_ff];
   assign rsp_ch.kind        = bundle_ff.kind;
   assign rsp_ch.last_of_run = b_last;

   always_comb begin
      a_valid_in = a_valid_ff;
      a_byte_in  = a_byte_ff;
      a_end_in   = a_end_ff;
      if (req_take) begin
         a_valid_in = req_ch.valid;
         a_byte_in  = req_ch.data_byte;
         a_end_in   = req_ch.end_mark;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (a_adv) begin
         state_in = dec_state;
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      bundle_in  = bundle_ff;
      idx_in     = idx_ff;
      if (a_adv && (dec_res.count != 3'd0)) begin
         // The result stage is free here, so a new set can be loaded.
         b_valid_in = 1'b1;
         bundle_in  = dec_res;
         idx_in     = 2'd0;
      end else if (b_valid_ff && rsp_ch.ready) begin
         if (b_last) begin
            b_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         idx_ff     <= 2'd0;
         state_ff   <= STATE_CLEAR;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         idx_ff     <= idx_in;
         state_ff   <= state_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      a_byte_ff <= a_byte_in;
      a_end_ff  <= a_end_in;
      bundle_ff <= bundle_in;
   end

endmodule

>>> design/jsu_decode.sv
// ----------------------------------------------------------------------------
// JSON unescaper byte decoder
// Next-state and result logic for one byte of the string token.
// ----------------------------------------------------------------------------
module jsu_decode
   import jsu_pkg::*;
(
   input  jsu_state_type  cur,
   input  logic [7:0]     data_byte,
   input  logic           end_mark,
   output jsu_state_type  nxt,
   output jsu_bundle_type res
);

   // Value of an ASCII hex digit; bit 4 flags a valid digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= "0" && b <= "9") begin
         r = {1'b1, 4'(b - "0")};
      end else if (b >= "a" && b <= "f") begin
         r = {1'b1, 4'(b - "a" + 8'd10)};
      end else if (b >= "A" && b <= "F") begin
         r = {1'b1, 4'(b - "A" + 8'd10)};
      end
      return r;
   endfunction

   // UTF-8 encoding of a code point as a data bundle.
   function automatic jsu_bundle_type utf8_encode(input logic [20:0] cp);
      jsu_bundle_type r;
      r = '0;
      r.kind = KIND_DATA;
      if (cp <= 21'h7f) begin
         r.count    = 3'd1;
         r.bytes[0] = cp[7:0];
      end else if (cp <= 21'h7ff) begin
         r.count    = 3'd2;
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hffff) begin
         r.count    = 3'd3;
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         r.count    = 3'd4;
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

   logic [4:0]  hex;
   logic [15:0] acc_hex;
   logic [20:0] acc_utf;
   logic [20:0] pair_cp;
   logic [20:0] cp_sel;
   logic [20:0] utf_min;
   logic [2:0]  held_idx;
   logic        do_fail;

   assign hex      = hex_digit(data_byte);
   assign acc_hex  = {cur.acc[11:0], hex[3:0]};
   assign acc_utf  = {cur.acc[14:0], data_byte[5:0]};
   assign pair_cp  = 21'h10000 + {1'b0, cur.hi, acc_hex[9:0]};
   assign cp_sel   = (cur.mode == MODE_HEX2) ? pair_cp : {5'd0, acc_hex};
   assign held_idx = {1'b0, cur.cls} - {1'b0, cur.cont} + 3'd1;

   always_comb begin
      case (cur.cls)
         2'd1:    utf_min = 21'h80;
         2'd2:    utf_min = 21'h800;
         default: utf_min = 21'h10000;
      endcase
   end

   always_comb begin
      nxt     = cur;
      res     = '0;
      res.kind = KIND_DATA;
      do_fail = 1'b0;

      if (end_mark) begin
         do_fail = (cur.mode != MODE_IDLE);
      end else begin
         case (cur.mode)
            MODE_IDLE: begin
               if (data_byte == "\"") begin
                  nxt.mode = MODE_STR;
               end else begin
                  do_fail = 1'b1;
               end
            end
            MODE_STR: begin
               if (data_byte == "\"") begin
                  res.count = 3'd1;
                  res.kind  = KIND_QUOTE;
                  nxt       = STATE_CLEAR;
                  nxt.held  = cur.held;
               end else if (data_byte < 8'h20) begin
                  do_fail = 1'b1;
               end else if (data_byte == "\\") begin
                  nxt.mode = MODE_ESC;
               end else if (data_byte < 8'h80) begin
                  res.count    = 3'd1;
                  res.bytes[0] = data_byte;
               end else if (data_byte[7:5] == 3'b110) begin
                  nxt.acc     = {16'd0, data_byte[4:0]};
                  nxt.held[0] = data_byte;
                  nxt.cls     = 2'd1;
                  nxt.cont    = 2'd1;
                  nxt.mode    = MODE_UTF8;
               end else if (data_byte[7:4] == 4'b1110) begin
                  nxt.acc     = {17'd0, data_byte[3:0]};
                  nxt.held[0] = data_byte;
                  nxt.cls     = 2'd2;
                  nxt.cont    = 2'd2;
                  nxt.mode    = MODE_UTF8;
               end else if (data_byte[7:3] == 5'b11110) begin
                  nxt.acc     = {18'd0, data_byte[2:0]};
                  nxt.held[0] = data_byte;
                  nxt.cls     = 2'd3;
                  nxt.cont    = 2'd3;
                  nxt.mode    = MODE_UTF8;
               end else begin
                  do_fail = 1'b1;
               end
            end
            MODE_UTF8: begin
               if (data_byte[7:6] != 2'b10) begin
                  do_fail = 1'b1;
               end else if (cur.cont > 2'd1) begin
                  nxt.acc  = acc_utf;
                  nxt.cont = cur.cont - 2'd1;
                  if (held_idx < 3'd3) begin
                     nxt.held[held_idx[1:0]] = data_byte;
                  end
               end else if (acc_utf < utf_min || acc_utf > 21'h10ffff ||
                            (acc_utf >= 21'hd800 && acc_utf <= 21'hdfff)) begin
                  do_fail = 1'b1;
               end else begin
                  // Replay the held lead and continuation bytes, then this one.
                  res.count = {1'b0, cur.cls} + 3'd1;
                  case (cur.cls)
                     2'd1: begin
                        res.bytes[0] = cur.held[0];
                        res.bytes[1] = data_byte;
                     end
                     2'd2: begin
                        res.bytes[0] = cur.held[0];
                        res.bytes[1] = cur.held[1];
                        res.bytes[2] = data_byte;
                     end
                     2'd3: begin
                        res.bytes[0] = cur.held[0];
                        res.bytes[1] = cur.held[1];
                        res.bytes[2] = cur.held[2];
                        res.bytes[3] = data_byte;
                     end
                     default: begin
                        res.bytes[0] = data_byte;
                     end
                  endcase
                  nxt.cont = 2'd0;
                  nxt.cls  = 2'd0;
                  nxt.acc  = 21'd0;
                  nxt.mode = MODE_STR;
               end
            end
            MODE_ESC: begin
               res.count = 3'd1;
               nxt.mode  = MODE_STR;
               case (data_byte)
                  "\"", "\\", "/": res.bytes[0] = data_byte;
                  "b":             res.bytes[0] = 8'h08;
                  "f":             res.bytes[0] = 8'h0c;
                  "n":             res.bytes[0] = 8'h0a;
                  "r":             res.bytes[0] = 8'h0d;
                  "t":             res.bytes[0] = 8'h09;
                  "u": begin
                     res.count    = 3'd0;
                     nxt.mode     = MODE_HEX1;
                     nxt.hex_left = 3'd4;
                     nxt.acc      = 21'd0;
                  end
                  default: do_fail = 1'b1;
               endcase
            end
            MODE_HEX1, MODE_HEX2: begin
               if (!hex[4]) begin
                  do_fail = 1'b1;
               end else if (cur.hex_left > 3'd1) begin
                  nxt.acc      = {5'd0, acc_hex};
                  nxt.hex_left = cur.hex_left - 3'd1;
               end else begin
                  nxt.hex_left = 3'd0;
                  nxt.acc      = 21'd0;
                  if (cur.mode == MODE_HEX1) begin
                     if (acc_hex >= 16'hd800 && acc_hex <= 16'hdbff) begin
                        nxt.hi   = acc_hex[9:0];
                        nxt.mode = MODE_NEED_BS;
                     end else if (acc_hex >= 16'hdc00) begin
                        // A low surrogate with no high surrogate before it fails; above DFFF the value is encoded.
                        if (acc_hex <= 16'hdfff) begin
                           do_fail = 1'b1;
                        end else begin
                           res      = utf8_encode(cp_sel);
                           nxt.mode = MODE_STR;
                        end
                     end else begin
                        res      = utf8_encode(cp_sel);
                        nxt.mode = MODE_STR;
                     end
                  end else if (acc_hex < 16'hdc00 || acc_hex > 16'hdfff) begin
                     do_fail = 1'b1;
                  end else begin
                     res      = utf8_encode(cp_sel);
                     nxt.hi   = 10'd0;
                     nxt.mode = MODE_STR;
                  end
               end
            end
            MODE_NEED_BS: begin
               if (data_byte == "\\") begin
                  nxt.mode = MODE_NEED_U;
               end else begin
                  do_fail = 1'b1;
               end
            end
            MODE_NEED_U: begin
               if (data_byte == "u") begin
                  nxt.mode     = MODE_HEX2;
                  nxt.hex_left = 3'd4;
                  nxt.acc      = 21'd0;
               end else begin
                  do_fail = 1'b1;
               end
            end
            default: begin
               do_fail = 1'b1;
            end
         endcase
      end

      if (do_fail) begin
         res       = '0;
         res.count = 3'd1;
         res.kind  = KIND_ERROR;
         nxt       = STATE_CLEAR;
         nxt.held  = cur.held;
      end
   end

endmodule
